/* hdl/checked_integer_arith_unit_macros.svh */
// Assertion macros for the checked integer arithmetic unit.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef CHECKED_INTEGER_ARITH_UNIT_MACROS_SVH
`define CHECKED_INTEGER_ARITH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CIAU_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checked_integer_arith_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CIAU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checked_integer_arith_unit: next-cycle check failed");

`endif

/* hdl/ciau_pkg.sv */
// Shared types, codes and helper functions of the checked integer arithmetic unit.
// No dependencies; used by checked_integer_arith_unit.
`timescale 1ns / 1ps

package ciau_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MINUS_ONE     = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] ONE           = {{(DATA_W-1){1'b0}}, 1'b1};

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_SUB = 2'd0;
    localparam mode_t MODE_DIV = 2'd1;
    localparam mode_t MODE_MOD = 2'd2;
    localparam mode_t MODE_POW = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_EXACT    = 2'd0;
    localparam status_t ST_DIV_ZERO = 2'd1;
    localparam status_t ST_NOT_INT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV_LOOP,
        S_DIV_FIX,
        S_POW_STEP,
        S_POW_SHIFT,
        S_MUL_LOOP,
        S_MUL_END,
        S_DONE
    } state_t;

    // Two's-complement negation.
    function automatic logic [DATA_W-1:0] neg64(input logic [DATA_W-1:0] x);
        neg64 = ~x + ONE;
    endfunction

    // Unsigned magnitude of a signed word; the most negative value maps to 2^63.
    function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] x);
        mag64 = x[DATA_W-1] ? neg64(x) : x;
    endfunction

endpackage

/* hdl/checked_integer_arith_unit.sv */
// Top level of the checked signed 64-bit integer arithmetic unit.
// Depends on ciau_pkg and on checked_integer_arith_unit_macros.svh for assertions.
`timescale 1ns / 1ps
`include "checked_integer_arith_unit_macros.svh"

// The unit takes one transaction at a time: a mode (subtract, divide, modulo
// or power) and two signed 64-bit operands, and returns one transaction with a
// 64-bit value and a status (exact, division by zero, or result not a 64-bit
// integer). Subtraction, the divide steps and the multiply additions share a
// single 65-bit add/subtract unit that a small sequencer reuses: divide and
// modulo run a restoring shift-subtract loop, and power runs exponentiation by
// squaring where every multiply is a shift-add loop with overflow detection.
// Subtract and the trivial divide and modulo cases go from the start state
// straight to the result; a real divide or modulo first runs the 64 steps of
// the shift-subtract loop. Power handles the exponent bits one at a time, with
// one multiply for each set bit and one squaring while bits remain; a multiply
// steps through the bits of the multiplier magnitude and stops early as soon
// as overflow is seen, so large bases finish quickly. The input is not ready
// while a transaction is in progress; a finished result sits in an output
// register, so the next input is taken while that result waits to be read.

module checked_integer_arith_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic signed [63:0]  left_operand,
    input  logic signed [63:0]  right_operand,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [63:0]  value,
    output logic [1:0]          status
);

    localparam int W = ciau_pkg::DATA_W;
    localparam logic [ciau_pkg::CNT_W-1:0] DIV_LAST = ciau_pkg::CNT_W'(W - 1);
    localparam logic [ciau_pkg::CNT_W-1:0] CNT_STEP = {{(ciau_pkg::CNT_W-1){1'b0}}, 1'b1};

    // Control state.
    ciau_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    // Operand and working registers.
    ciau_pkg::mode_t  mode_reg, mode_next;
    logic [W-1:0]     opa_reg, opa_next;      // left operand, later the running base
    logic [W-1:0]     opb_reg, opb_next;      // right operand, later the exponent
    logic [W-1:0]     acc_reg, acc_next;      // power accumulator
    logic [W-1:0]     mx_reg, mx_next;        // multiplicand or divisor
    logic [W-1:0]     my_reg, my_next;        // multiplier or dividend/quotient
    logic [W-1:0]     mp_reg, mp_next;        // product or partial remainder
    logic             xo_reg, xo_next;        // multiplicand has grown past 64 bits
    logic             neg_reg, neg_next;      // sign to apply to the result
    logic             tgt_acc_reg, tgt_acc_next;
    logic [ciau_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // Pending result and output registers.
    logic [W-1:0]       res_value_reg, res_value_next;
    ciau_pkg::status_t  res_status_reg, res_status_next;
    logic [W-1:0]       value_reg, value_next;
    ciau_pkg::status_t  status_reg, status_next;

    // Shared add/subtract unit.
    logic [W-1:0] alu_a;
    logic [W-1:0] alu_b;
    logic         alu_sub;
    logic [W:0]   alu_sum;

    logic [W-1:0] rem_shift;
    logic [W-1:0] exp_shift;
    logic         over_limit;

    assign rem_shift = {mp_reg[W-2:0], my_reg[W-1]};
    assign exp_shift = opb_reg >> 1;
    // A negative product may reach 2^63 in magnitude, a positive one only 2^63 - 1.
    assign over_limit = neg_reg ? (mp_reg > ciau_pkg::MOST_NEGATIVE) : mp_reg[W-1];

    always_comb
    begin
        case (state_reg)
            ciau_pkg::S_START:
            begin
                alu_a   = opa_reg;
                alu_b   = opb_reg;
                alu_sub = 1'b1;
            end
            ciau_pkg::S_DIV_LOOP:
            begin
                alu_a   = rem_shift;
                alu_b   = mx_reg;
                alu_sub = 1'b1;
            end
            ciau_pkg::S_MUL_LOOP:
            begin
                alu_a   = mp_reg;
                alu_b   = mx_reg;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // On subtract the carry out is set when no borrow occurs.
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (W+1)'(alu_sub);

    assign in_ready  = (state_reg == ciau_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mode_next       = mode_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        acc_next        = acc_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        mp_next         = mp_reg;
        xo_next         = xo_reg;
        neg_next        = neg_reg;
        tgt_acc_next    = tgt_acc_reg;
        cnt_next        = cnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        value_next      = value_reg;
        status_next     = status_reg;

        case (state_reg)
            ciau_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    opa_next   = left_operand;
                    opb_next   = right_operand;
                    state_next = ciau_pkg::S_START;
                end
            end

            ciau_pkg::S_START:
            begin
                res_value_next  = '0;
                res_status_next = ciau_pkg::ST_EXACT;
                case (mode_reg)
                    ciau_pkg::MODE_SUB:
                    begin
                        // Overflow when the operand signs differ and the result sign
                        // differs from the minuend; the wrapped difference is kept.
                        res_value_next = alu_sum[W-1:0];
                        if ((opa_reg[W-1] != opb_reg[W-1]) && (alu_sum[W-1] != opa_reg[W-1]))
                        begin
                            res_status_next = ciau_pkg::ST_NOT_INT;
                        end
                        state_next = ciau_pkg::S_DONE;
                    end
                    ciau_pkg::MODE_DIV, ciau_pkg::MODE_MOD:
                    begin
                        mx_next  = ciau_pkg::mag64(opb_reg);
                        my_next  = ciau_pkg::mag64(opa_reg);
                        mp_next  = '0;
                        cnt_next = '0;
                        neg_next = (mode_reg == ciau_pkg::MODE_DIV)
                                   ? (opa_reg[W-1] ^ opb_reg[W-1]) : opa_reg[W-1];
                        if (opb_reg == '0)
                        begin
                            res_status_next = ciau_pkg::ST_DIV_ZERO;
                            state_next      = ciau_pkg::S_DONE;
                        end
                        else if (mode_reg == ciau_pkg::MODE_DIV
                                 && opa_reg == ciau_pkg::MOST_NEGATIVE
                                 && opb_reg == ciau_pkg::MINUS_ONE)
                        begin
                            res_status_next = ciau_pkg::ST_NOT_INT;
                            state_next      = ciau_pkg::S_DONE;
                        end
                        else if (mode_reg == ciau_pkg::MODE_MOD
                                 && opb_reg == ciau_pkg::MINUS_ONE)
                        begin
                            state_next = ciau_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ciau_pkg::S_DIV_LOOP;
                        end
                    end
                    default:
                    begin
                        acc_next = ciau_pkg::ONE;
                        if (opb_reg[W-1])
                        begin
                            res_status_next = ciau_pkg::ST_NOT_INT;
                            state_next      = ciau_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ciau_pkg::S_POW_STEP;
                        end
                    end
                endcase
            end

            ciau_pkg::S_DIV_LOOP:
            begin
                // Restoring division: one quotient bit per cycle, MSB first.
                if (alu_sum[W])
                begin
                    mp_next = alu_sum[W-1:0];
                end
                else
                begin
                    mp_next = rem_shift;
                end
                my_next  = {my_reg[W-2:0], alu_sum[W]};
                cnt_next = cnt_reg + CNT_STEP;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ciau_pkg::S_DIV_FIX;
                end
            end

            ciau_pkg::S_DIV_FIX:
            begin
                res_value_next  = '0;
                res_status_next = ciau_pkg::ST_EXACT;
                if (mode_reg == ciau_pkg::MODE_DIV)
                begin
                    if (mp_reg != '0)
                    begin
                        res_status_next = ciau_pkg::ST_NOT_INT;
                    end
                    else
                    begin
                        res_value_next = neg_reg ? ciau_pkg::neg64(my_reg) : my_reg;
                    end
                end
                else
                begin
                    res_value_next = neg_reg ? ciau_pkg::neg64(mp_reg) : mp_reg;
                end
                state_next = ciau_pkg::S_DONE;
            end

            ciau_pkg::S_POW_STEP:
            begin
                if (opb_reg == '0)
                begin
                    res_value_next  = acc_reg;
                    res_status_next = ciau_pkg::ST_EXACT;
                    state_next      = ciau_pkg::S_DONE;
                end
                else if (opb_reg[0])
                begin
                    // Multiply the accumulator by the running base.
                    mx_next      = ciau_pkg::mag64(acc_reg);
                    my_next      = ciau_pkg::mag64(opa_reg);
                    mp_next      = '0;
                    xo_next      = 1'b0;
                    neg_next     = acc_reg[W-1] ^ opa_reg[W-1];
                    tgt_acc_next = 1'b1;
                    state_next   = ciau_pkg::S_MUL_LOOP;
                end
                else
                begin
                    state_next = ciau_pkg::S_POW_SHIFT;
                end
            end

            ciau_pkg::S_POW_SHIFT:
            begin
                opb_next = exp_shift;
                if (exp_shift != '0)
                begin
                    // Square the running base only while exponent bits remain.
                    mx_next      = ciau_pkg::mag64(opa_reg);
                    my_next      = ciau_pkg::mag64(opa_reg);
                    mp_next      = '0;
                    xo_next      = 1'b0;
                    neg_next     = 1'b0;
                    tgt_acc_next = 1'b0;
                    state_next   = ciau_pkg::S_MUL_LOOP;
                end
                else
                begin
                    state_next = ciau_pkg::S_POW_STEP;
                end
            end

            ciau_pkg::S_MUL_LOOP:
            begin
                if (my_reg == '0)
                begin
                    state_next = ciau_pkg::S_MUL_END;
                end
                else if (my_reg[0] && (xo_reg || alu_sum[W]))
                begin
                    // The product has reached 2^64 and cannot fit.
                    res_value_next  = '0;
                    res_status_next = ciau_pkg::ST_NOT_INT;
                    state_next      = ciau_pkg::S_DONE;
                end
                else
                begin
                    if (my_reg[0])
                    begin
                        mp_next = alu_sum[W-1:0];
                    end
                    mx_next = mx_reg << 1;
                    xo_next = xo_reg | mx_reg[W-1];
                    my_next = my_reg >> 1;
                end
            end

            ciau_pkg::S_MUL_END:
            begin
                if (over_limit)
                begin
                    res_value_next  = '0;
                    res_status_next = ciau_pkg::ST_NOT_INT;
                    state_next      = ciau_pkg::S_DONE;
                end
                else if (tgt_acc_reg)
                begin
                    acc_next   = neg_reg ? ciau_pkg::neg64(mp_reg) : mp_reg;
                    state_next = ciau_pkg::S_POW_SHIFT;
                end
                else
                begin
                    opa_next   = mp_reg;
                    state_next = ciau_pkg::S_POW_STEP;
                end
            end

            ciau_pkg::S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    value_next     = res_value_reg;
                    status_next    = res_status_reg;
                    out_valid_next = 1'b1;
                    state_next     = ciau_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ciau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ciau_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        acc_reg        <= acc_next;
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        mp_reg         <= mp_next;
        xo_reg         <= xo_next;
        neg_reg        <= neg_next;
        tgt_acc_reg    <= tgt_acc_next;
        cnt_reg        <= cnt_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        value_reg      <= value_next;
        status_reg     <= status_next;
    end

    // An accepted transaction keeps the input closed in the following cycle.
    `CIAU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // The partial remainder always stays below the divisor.
    `CIAU_ASSERT_SAME(a_rem_below_div, state_reg == ciau_pkg::S_DIV_LOOP, mp_reg < mx_reg)
    // A division by zero reports a zero value.
    `CIAU_ASSERT_SAME(a_div_zero_value, out_valid && status == ciau_pkg::ST_DIV_ZERO, value == '0)
    // Only the three defined status codes ever appear.
    `CIAU_ASSERT_SAME(a_status_code, out_valid, status <= ciau_pkg::ST_NOT_INT)

endmodule
